FILE: rtl/owner_locked_lifo_stack_macros.svh
// assertion macros for the owner-locked lifo stack
// expects clk and rst_n in the scope of the module that uses them
`ifndef OWNER_LOCKED_LIFO_STACK_MACROS_SVH
`define OWNER_LOCKED_LIFO_STACK_MACROS_SVH

// same-cycle implication, disabled during reset
`define OLLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owner_locked_lifo_stack: check failed");

// next-cycle implication, disabled during reset
`define OLLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owner_locked_lifo_stack: check failed");

`endif

FILE: rtl/olls_pkg.sv
// shared types, codes and defaults for the owner-locked lifo stack
// no dependencies
`default_nettype none

package olls_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int REQ_COUNT_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // request commands
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOCKED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    // shift command for the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

`default_nettype wire

FILE: rtl/olls_cell.sv
// one entry of the shifting stack chain
// depends on olls_pkg
`default_nettype none

module olls_cell (
    input  wire logic                         clk,
    input  wire olls_pkg::shift_t             shift,
    input  wire logic [olls_pkg::DATA_W-1:0]  from_above,
    input  wire logic [olls_pkg::DATA_W-1:0]  from_below,
    output logic      [olls_pkg::DATA_W-1:0]  q
);

    logic [olls_pkg::DATA_W-1:0] data_reg;
    logic [olls_pkg::DATA_W-1:0] data_next;

    // push moves entries away from the top, pop moves them toward it
    always_comb
    begin
        data_next = data_reg;
        if (shift.push)
        begin
            data_next = from_above;
        end
        else if (shift.pop)
        begin
            data_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

FILE: rtl/olls_ctrl.sv
// lock, fill count and status decision for the owner-locked lifo stack
// depends on olls_pkg and owner_locked_lifo_stack_macros.svh
`default_nettype none

`include "owner_locked_lifo_stack_macros.svh"

module olls_ctrl #(
    parameter int STACK_DEPTH     = olls_pkg::DEPTH_DEF,
    parameter int REQUESTER_COUNT = olls_pkg::REQ_COUNT_DEF,
    localparam int CNT_W          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [olls_pkg::CMD_W-1:0]      cmd,
    input  wire logic [olls_pkg::ID_W-1:0]       requester,
    output olls_pkg::shift_t                     shift,
    output logic      [olls_pkg::STATUS_W-1:0]   status,
    output logic      [CNT_W-1:0]                position
);

    localparam int ID_COUNT = 2 ** olls_pkg::ID_W;

    logic                        lock_held_reg;
    logic                        lock_held_next;
    logic [olls_pkg::ID_W-1:0]   lock_owner_reg;
    logic [olls_pkg::ID_W-1:0]   lock_owner_next;
    logic [CNT_W-1:0]            fill_count_reg;
    logic [CNT_W-1:0]            fill_count_next;

    logic [olls_pkg::ID_W-1:0]   id_map [ID_COUNT];
    logic [olls_pkg::ID_W-1:0]   who;
    logic                        blocked;
    logic                        full;
    logic                        empty;

    // id reduction table, folded at elaboration
    for (genvar i = 0; i < ID_COUNT; i++)
    begin : g_id_map
        assign id_map[i] = olls_pkg::ID_W'(i % REQUESTER_COUNT);
    end

    assign who     = id_map[requester];
    assign blocked = lock_held_reg && (lock_owner_reg != who);
    assign full    = (fill_count_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (fill_count_reg == '0);

    always_comb
    begin
        status          = olls_pkg::ST_OK;
        position        = '0;
        shift           = '0;
        lock_held_next  = lock_held_reg;
        lock_owner_next = lock_owner_reg;
        fill_count_next = fill_count_reg;
        unique case (cmd)
            olls_pkg::CMD_PUSH:
            begin
                if (blocked)
                begin
                    status = olls_pkg::ST_LOCKED;
                end
                else if (full)
                begin
                    status = olls_pkg::ST_FULL;
                end
                else
                begin
                    position        = fill_count_reg;
                    shift.push      = 1'b1;
                    fill_count_next = fill_count_reg + 1'b1;
                end
            end
            olls_pkg::CMD_POP:
            begin
                if (empty)
                begin
                    status = olls_pkg::ST_EMPTY;
                end
                else if (blocked)
                begin
                    status = olls_pkg::ST_LOCKED;
                end
                else
                begin
                    position        = fill_count_reg - 1'b1;
                    shift.pop       = 1'b1;
                    fill_count_next = fill_count_reg - 1'b1;
                end
            end
            olls_pkg::CMD_LOCK:
            begin
                if (lock_held_reg)
                begin
                    status = olls_pkg::ST_LOCKED;
                end
                else
                begin
                    lock_held_next  = 1'b1;
                    lock_owner_next = who;
                end
            end
            olls_pkg::CMD_UNLOCK:
            begin
                if (!lock_held_reg)
                begin
                    status = olls_pkg::ST_NOT_LOCKED;
                end
                else if (lock_owner_reg != who)
                begin
                    status = olls_pkg::ST_NOT_OWNER;
                end
                else
                begin
                    lock_held_next  = 1'b0;
                    lock_owner_next = '0;
                end
            end
            default:
            begin
                status = olls_pkg::ST_OK;
            end
        endcase
        if (!accept)
        begin
            shift = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_held_reg  <= 1'b0;
            lock_owner_reg <= '0;
            fill_count_reg <= '0;
        end
        else if (accept)
        begin
            lock_held_reg  <= lock_held_next;
            lock_owner_reg <= lock_owner_next;
            fill_count_reg <= fill_count_next;
        end
    end

    `OLLS_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_reg <= CNT_W'(STACK_DEPTH))
    `OLLS_ASSERT_NOW(a_free_owner_zero, !lock_held_reg, lock_owner_reg == '0)
    `OLLS_ASSERT_NEXT(a_push_grows, accept && shift.push,
        fill_count_reg == CNT_W'($past(fill_count_reg) + 1'b1))
    `OLLS_ASSERT_NEXT(a_refused_holds, accept && (status != olls_pkg::ST_OK),
        $stable(fill_count_reg) && $stable(lock_held_reg) && $stable(lock_owner_reg))

endmodule

`default_nettype wire

FILE: rtl/owner_locked_lifo_stack.sv
// owner-locked lifo stack top level: a chain of shifting cells with the top entry in cell 0
// result: registered, valid in the cycle after request acceptance, held until taken
// throughput: one request per cycle while results are taken; a new request is taken while the result drains
// reset: asynchronous active low, clears lock, owner, fill count and result valid
// depends on olls_pkg, olls_cell and olls_ctrl; cell contents are not reset
`default_nettype none

module owner_locked_lifo_stack #(
    parameter int STACK_DEPTH     = olls_pkg::DEPTH_DEF,
    parameter int REQUESTER_COUNT = olls_pkg::REQ_COUNT_DEF,
    localparam int CNT_W          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [olls_pkg::CMD_W-1:0]   cmd,
    input  wire logic        [olls_pkg::ID_W-1:0]    requester,
    input  wire logic signed [olls_pkg::DATA_W-1:0]  push_value,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [olls_pkg::STATUS_W-1:0] status,
    output logic signed      [olls_pkg::DATA_W-1:0]  pop_value,
    output logic             [CNT_W-1:0]             position
);

    logic                           accept;
    olls_pkg::shift_t               shift;
    logic [olls_pkg::STATUS_W-1:0]  status_next;
    logic [CNT_W-1:0]               position_next;
    logic [olls_pkg::DATA_W-1:0]    pop_value_next;

    // cell outputs, cell 0 is the top of stack
    logic [olls_pkg::DATA_W-1:0]    cell_q [STACK_DEPTH];

    // result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [olls_pkg::STATUS_W-1:0]  status_reg;
    logic [olls_pkg::DATA_W-1:0]    pop_value_reg;
    logic [CNT_W-1:0]               position_reg;

    // a new request enters whenever the result register is empty or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // lock, owner and fill count bookkeeping plus the status decision
    olls_ctrl #(
        .STACK_DEPTH     (STACK_DEPTH),
        .REQUESTER_COUNT (REQUESTER_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .requester (requester),
        .shift     (shift),
        .status    (status_next),
        .position  (position_next)
    );

    // the chain: push shifts every entry one cell deeper and loads cell 0,
    // pop shifts every entry one cell up so the next value lands in cell 0
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [olls_pkg::DATA_W-1:0] above;
        logic [olls_pkg::DATA_W-1:0] below;

        if (i == 0)
        begin : g_head
            assign above = push_value;
        end
        else
        begin : g_body
            assign above = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = cell_q[i+1];
        end

        olls_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .q          (cell_q[i])
        );
    end

    // the popped value is the current top, zero for everything else
    assign pop_value_next = shift.pop ? cell_q[0] : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
            position_reg  <= position_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;
    assign position  = position_reg;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the owner-locked lifo stack: directed and random requests
// with an in-line stack and lock predictor; depends on olls_pkg and owner_locked_lifo_stack
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import olls_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int REQ_COUNT  = REQ_COUNT_DEF;
    localparam int POS_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int HOLD_LEN   = 400;
    localparam int QUIET_MAX  = 2000;
    localparam int BATCH_SIZE = 290;

    // one request as the sender offers it
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   who;
        logic [DATA_W-1:0] value;
    } request_t;

    // one result as the stack returns it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   popped;
        logic [POS_W-1:0]    slot;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = CMD_PUSH;
    logic [ID_W-1:0]          requester = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] pop_value;
    logic [POS_W-1:0]         position;

    // requests waiting to be offered, results waiting to come back
    request_t request_queue[$];
    result_t  awaited_results[$];

    int mismatches = 0;
    int added = 0;

    // calm turns off idling on both sides; hold_asks starts a long receiver stall
    bit calm = 1'b0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;

    // predictor copy of the stack and the lock
    logic [DATA_W-1:0] shadow_store [DEPTH];
    logic [POS_W-1:0]  shadow_fill = '0;
    bit                shadow_locked = 1'b0;
    logic [ID_W-1:0]   shadow_owner = '0;

    // lock state as the stimulus generator sees it, used to build clean sessions
    bit              gen_locked = 1'b0;
    logic [ID_W-1:0] gen_owner = '0;

    owner_locked_lifo_stack i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .requester  (requester),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .pop_value  (pop_value),
        .position   (position)
    );

    always #1 clk = ~clk;

    // expected result of one request, updating the shadow stack and lock
    function automatic result_t stack_predict(request_t r);
        result_t         res;
        logic [ID_W-1:0] id;
        bit              blocked;
        res.status = ST_OK;
        res.popped = '0;
        res.slot   = '0;
        id = ID_W'(int'(r.who) % REQ_COUNT);
        // another requester holds the lock
        blocked = shadow_locked && (shadow_owner != id);
        case (r.cmd)
            CMD_PUSH:
            begin
                // lock is checked before fullness
                if (blocked)
                    res.status = ST_LOCKED;
                else if (shadow_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    res.slot = shadow_fill;
                    shadow_store[IDX_W'(shadow_fill)] = r.value;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            CMD_POP:
            begin
                // emptiness is checked before the lock
                if (shadow_fill == 0)
                    res.status = ST_EMPTY;
                else if (blocked)
                    res.status = ST_LOCKED;
                else
                begin
                    shadow_fill = shadow_fill - 1'b1;
                    res.slot    = shadow_fill;
                    res.popped  = shadow_store[IDX_W'(shadow_fill)];
                end
            end
            CMD_LOCK:
            begin
                // relocking fails even for the owner
                if (shadow_locked)
                    res.status = ST_LOCKED;
                else
                begin
                    shadow_locked = 1'b1;
                    shadow_owner  = id;
                end
            end
            default:
            begin
                // not-locked comes before the owner check
                if (!shadow_locked)
                    res.status = ST_NOT_LOCKED;
                else if (shadow_owner != id)
                    res.status = ST_NOT_OWNER;
                else
                begin
                    shadow_locked = 1'b0;
                    shadow_owner  = '0;
                end
            end
        endcase
        return res;
    endfunction

    // queue one request and follow the lock it leaves behind
    task automatic add_request(logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [DATA_W-1:0] v);
        request_t r;
        r.cmd   = c;
        r.who   = id;
        r.value = v;
        request_queue.push_back(r);
        added++;
        if (c == CMD_LOCK && !gen_locked)
        begin
            gen_locked = 1'b1;
            gen_owner  = id;
        end
        else if (c == CMD_UNLOCK && gen_locked && gen_owner == id)
            gen_locked = 1'b0;
    endtask

    // random data, now and then one of the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(15) == 0)
        begin
            case ($urandom_range(3))
                0: v = 32'h0000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h8000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        return v;
    endfunction

    // a well-formed owner session: lock, a few pushes and pops, unlock,
    // with the odd request from an intruder in between
    task automatic add_session(int push_pct);
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] other;
        int              n;
        if (gen_locked)
            add_request(CMD_UNLOCK, gen_owner, pick_value());
        id = ID_W'($urandom_range(REQ_COUNT - 1));
        n  = $urandom_range(1, 8);
        add_request(CMD_LOCK, id, pick_value());
        repeat (n)
        begin
            if ($urandom_range(99) < 10)
            begin
                other = ID_W'((int'(id) + $urandom_range(1, REQ_COUNT - 1)) % REQ_COUNT);
                add_request($urandom_range(99) < 50 ? CMD_PUSH : CMD_POP, other, pick_value());
            end
            else
                add_request($urandom_range(99) < push_pct ? CMD_PUSH : CMD_POP, id,
                            pick_value());
        end
        add_request(CMD_UNLOCK, id, pick_value());
    endtask

    // one random request of any kind
    task automatic add_noise(int push_pct);
        logic [CMD_W-1:0] c;
        if ($urandom_range(99) < 25)
            c = $urandom_range(99) < 50 ? CMD_LOCK : CMD_UNLOCK;
        else
            c = $urandom_range(99) < push_pct ? CMD_PUSH : CMD_POP;
        add_request(c, ID_W'($urandom_range(REQ_COUNT - 1)), pick_value());
    endtask

    // sender pause: nothing left to offer, nothing on the wire and every result back
    task automatic wait_drained();
        @(negedge clk);
        while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: a new request is put out only when the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 7))
            begin
                in_valid   <= 1'b1;
                cmd        <= request_queue[0].cmd;
                requester  <= request_queue[0].who;
                push_value <= request_queue[0].value;
                void'(request_queue.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random idling, plus a long stall on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_asks != hold_done)
        begin
            hold_done <= hold_asks;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || $urandom_range(99) >= 7;
    end

    // monitor: check the result first, then predict the request taken at this edge
    always @(posedge clk)
    begin
        result_t  want;
        request_t taken;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: status %0d pop_value %h position %0d",
                                 status, pop_value, position);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || pop_value !== want.popped
                        || position !== want.slot)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("result differs (expected/actual): status %0d/%0d ",
                                   want.status, status);
                            $display("pop_value %h/%h position %0d/%0d",
                                     want.popped, pop_value, want.slot, position);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken.cmd   = cmd;
                taken.who   = requester;
                taken.value = push_value;
                awaited_results.push_back(stack_predict(taken));
            end
        end
    end

    // watchdog: too long without any request or result moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("owner_locked_lifo_stack: mismatch");
        $finish;
    end

    // stimulus sequencing
    initial
    begin
        int push_pct;
        // unlock and pop on a fresh stack
        add_request(CMD_UNLOCK, 4'd0, 32'h0);
        add_request(CMD_POP, 4'd15, 32'hffff_ffff);
        add_request(CMD_PUSH, 4'd0, 32'h7fff_ffff);
        add_request(CMD_PUSH, 4'd15, 32'h8000_0000);
        // relock by the owner and by a stranger both fail
        add_request(CMD_LOCK, 4'd3, 32'h0);
        add_request(CMD_LOCK, 4'd3, 32'h0);
        add_request(CMD_LOCK, 4'd12, 32'h0);
        // stranger is refused push, pop and unlock
        add_request(CMD_PUSH, 4'd12, 32'h1234_5678);
        add_request(CMD_POP, 4'd12, 32'h0);
        add_request(CMD_UNLOCK, 4'd12, 32'h0);
        // owner keeps working, then releases
        add_request(CMD_PUSH, 4'd3, 32'hffff_ffff);
        add_request(CMD_POP, 4'd3, 32'h0);
        add_request(CMD_UNLOCK, 4'd3, 32'h0);
        add_request(CMD_POP, 4'd0, 32'h0);
        add_request(CMD_POP, 4'd15, 32'h0);
        add_request(CMD_POP, 4'd0, 32'h0);
        // empty wins over the lock on a pop
        add_request(CMD_LOCK, 4'd15, 32'h0);
        add_request(CMD_POP, 4'd0, 32'h0);
        add_request(CMD_POP, 4'd15, 32'h0);
        add_request(CMD_PUSH, 4'd15, 32'h0);
        add_request(CMD_UNLOCK, 4'd0, 32'h0);
        add_request(CMD_UNLOCK, 4'd15, 32'h0);
        add_request(CMD_POP, 4'd5, 32'h0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        // batches lean toward filling or draining so that full and empty both come up
        for (int b = 0; b < 5; b++)
        begin
            case (b)
                0, 2: push_pct = 80;
                1, 4: push_pct = 20;
                default: push_pct = 50;
            endcase
            calm  = (b == 3);
            added = 0;
            while (added < BATCH_SIZE)
            begin
                if ($urandom_range(99) < 70)
                    add_session(push_pct);
                else
                    add_noise(push_pct);
            end
            // long receiver stall while the sender keeps offering
            if (b == 1)
                hold_asks++;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("owner_locked_lifo_stack: match");
        else
            $display("owner_locked_lifo_stack: mismatch");
        $finish;
    end

endmodule
